// File: hw/rtl/mfsp_pkg.sv
// ----------------------------------------------------------------------------
// MIDI file stream parser package
// Shared result record, kind and error codes.
// ----------------------------------------------------------------------------
package mfsp_pkg;

  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_TRACK   = 3'd1;
  localparam logic [2:0] KIND_CHANNEL = 3'd2;
  localparam logic [2:0] KIND_META    = 3'd3;
  localparam logic [2:0] KIND_PAYLOAD = 3'd4;
  localparam logic [2:0] KIND_ERROR   = 3'd5;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_TAG   = 3'd1;
  localparam logic [2:0] ERR_HDR_LEN   = 3'd2;
  localparam logic [2:0] ERR_STATUS    = 3'd3;
  localparam logic [2:0] ERR_OVERRUN   = 3'd4;
  localparam logic [2:0] ERR_EMPTY     = 3'd5;
  localparam logic [2:0] ERR_TRUNCATED = 3'd6;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] delta_time;
    logic [3:0]  channel;
    logic [7:0]  event_code;
    logic [7:0]  data_first;
    logic [7:0]  data_second;
    logic [31:0] length;
    logic [15:0] header_format;
    logic [15:0] header_tracks;
    logic [15:0] header_division;
    logic        track_done;
    logic [2:0]  error_cause;
  } result_t;

endpackage

// File: hw/rtl/mfsp_front.sv
// ----------------------------------------------------------------------------
// MIDI file stream parser front end
// Takes one byte per beat, tracks chunk and event structure, and produces
// at most one result record per byte.
// ----------------------------------------------------------------------------
module mfsp_front #(
  parameter int DELTA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        data_byte,
  input  logic              final_byte,
  output logic              res_valid,
  output mfsp_pkg::result_t res
);

  typedef enum logic [11:0] {
    PH_HTAG   = 12'b000000000001,
    PH_HLEN   = 12'b000000000010,
    PH_HWORDS = 12'b000000000100,
    PH_TTAG   = 12'b000000001000,
    PH_TLEN   = 12'b000000010000,
    PH_DELTA  = 12'b000000100000,
    PH_STATUS = 12'b000001000000,
    PH_D1     = 12'b000010000000,
    PH_D2     = 12'b000100000000,
    PH_MTYPE  = 12'b001000000000,
    PH_VLEN   = 12'b010000000000,
    PH_PAY    = 12'b100000000000
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic [31:0]       word_r, word_nxt;
  logic [15:0]       hw0_r, hw1_r, hw2_r, hw0_nxt, hw1_nxt, hw2_nxt;
  logic [7:0]        rs_r, rs_nxt;
  logic              rsv_r, rsv_nxt;
  logic [31:0]       chunk_r, chunk_nxt;
  logic [DELTA_WIDTH-1:0] delta_r, delta_nxt;
  logic [31:0]       pay_r, pay_nxt;
  logic [7:0]        held_r, held_nxt;
  logic              err_r, err_nxt;

  logic [7:0]        tag_byte;
  logic [2:0]        cause;
  logic              complete, have, first_data;
  logic [3:0]        cnt_inc;
  mfsp_pkg::result_t r;

  always_comb begin
    tag_byte = 8'h00;
    unique case (cnt_r[1:0])
      2'd0: tag_byte = 8'h4d;
      2'd1: tag_byte = 8'h54;
      2'd2: tag_byte = (phase_r == PH_HTAG) ? 8'h68 : 8'h72;
      default: tag_byte = (phase_r == PH_HTAG) ? 8'h64 : 8'h6b;
    endcase
  end

  assign cnt_inc = {1'b0, cnt_r} + 4'd1;

  always_comb begin
    phase_nxt = phase_r; cnt_nxt = cnt_r; word_nxt = word_r;
    hw0_nxt = hw0_r; hw1_nxt = hw1_r; hw2_nxt = hw2_r;
    rs_nxt = rs_r; rsv_nxt = rsv_r; chunk_nxt = chunk_r;
    delta_nxt = delta_r; pay_nxt = pay_r; held_nxt = held_r; err_nxt = err_r;
    cause = mfsp_pkg::ERR_NONE; complete = 1'b0; have = 1'b0; first_data = 1'b0;
    r = '0;
    unique case (phase_r)
      PH_HTAG, PH_TTAG: begin
        if (data_byte != tag_byte) begin
          cause = mfsp_pkg::ERR_BAD_TAG;
        end else if (cnt_inc == 4'd4) begin
          cnt_nxt = 3'd0;
          word_nxt = '0;
          phase_nxt = (phase_r == PH_HTAG) ? PH_HLEN : PH_TLEN;
        end else begin
          cnt_nxt = cnt_inc[2:0];
        end
      end
      PH_HLEN, PH_TLEN: begin
        word_nxt = {word_r[23:0], data_byte};
        cnt_nxt = cnt_inc[2:0];
        if (cnt_inc == 4'd4) begin
          cnt_nxt = 3'd0;
          if (phase_r == PH_HLEN) begin
            if (word_nxt != 32'd6) cause = mfsp_pkg::ERR_HDR_LEN;
            else phase_nxt = PH_HWORDS;
          end else if (word_nxt == 32'd0) begin
            cause = mfsp_pkg::ERR_EMPTY;
          end else begin
            chunk_nxt = word_nxt;
            delta_nxt = '0;
            phase_nxt = PH_DELTA;
            r.kind = mfsp_pkg::KIND_TRACK;
            r.length = word_nxt;
            have = 1'b1;
          end
        end
      end
      PH_HWORDS: begin
        unique case (cnt_r[2:1])
          2'd0: hw0_nxt = {hw0_r[7:0], data_byte};
          2'd1: hw1_nxt = {hw1_r[7:0], data_byte};
          default: hw2_nxt = {hw2_r[7:0], data_byte};
        endcase
        cnt_nxt = cnt_inc[2:0];
        if (cnt_inc >= 4'd6) begin
          cnt_nxt = 3'd0;
          phase_nxt = PH_TTAG;
          r.kind = mfsp_pkg::KIND_HEADER;
          r.header_format = hw0_nxt;
          r.header_tracks = hw1_nxt;
          r.header_division = hw2_nxt;
          have = 1'b1;
        end
      end
      default: begin
        chunk_nxt = chunk_r - 32'd1;
        unique case (phase_r)
          PH_DELTA: begin
            delta_nxt = {delta_r[DELTA_WIDTH-8:0], 7'd0} +
                        DELTA_WIDTH'(data_byte[6:0]);
            if (!data_byte[7]) phase_nxt = PH_STATUS;
          end
          PH_STATUS: begin
            if (data_byte == 8'hff) begin
              phase_nxt = PH_MTYPE;
            end else if (data_byte == 8'hf0 || data_byte == 8'hf7) begin
              held_nxt = data_byte;
              word_nxt = '0;
              phase_nxt = PH_VLEN;
            end else if (data_byte[7]) begin
              rs_nxt = data_byte;
              rsv_nxt = 1'b1;
              if (data_byte < 8'hf0) phase_nxt = PH_D1;
              else cause = mfsp_pkg::ERR_STATUS;
            end else if (!rsv_r || !rs_r[7] || rs_r >= 8'hf0) begin
              cause = mfsp_pkg::ERR_STATUS;
            end else begin
              first_data = 1'b1;
            end
          end
          PH_D1: first_data = 1'b1;
          PH_D2: begin
            r.kind = mfsp_pkg::KIND_CHANNEL;
            r.data_first = held_r;
            r.data_second = data_byte;
            have = 1'b1;
            complete = 1'b1;
          end
          PH_MTYPE: begin
            held_nxt = data_byte;
            word_nxt = '0;
            phase_nxt = PH_VLEN;
          end
          PH_VLEN: begin
            word_nxt = {word_r[24:0], 7'd0} + {25'd0, data_byte[6:0]};
            if (!data_byte[7]) begin
              r.kind = mfsp_pkg::KIND_META;
              r.event_code = held_r;
              r.length = word_nxt;
              have = 1'b1;
              pay_nxt = word_nxt;
              if (word_nxt == 32'd0) complete = 1'b1;
              else phase_nxt = PH_PAY;
            end
          end
          default: begin
            r.kind = mfsp_pkg::KIND_PAYLOAD;
            r.event_code = held_r;
            r.data_first = data_byte;
            have = 1'b1;
            pay_nxt = pay_r - 32'd1;
            if (pay_nxt == 32'd0) complete = 1'b1;
          end
        endcase
        if (first_data) begin
          if (rs_nxt[7:4] != 4'hc && rs_nxt[7:4] != 4'hd) begin
            held_nxt = data_byte;
            phase_nxt = PH_D2;
          end else begin
            r.kind = mfsp_pkg::KIND_CHANNEL;
            r.data_first = data_byte;
            have = 1'b1;
            complete = 1'b1;
          end
        end
        if (have) begin
          r.delta_time = 32'(delta_nxt);
          if (r.kind == mfsp_pkg::KIND_CHANNEL) begin
            r.channel = rs_nxt[3:0];
            r.event_code = {rs_nxt[7:4], 4'h0};
          end
        end
        if (cause == mfsp_pkg::ERR_NONE) begin
          if (complete) begin
            delta_nxt = '0;
            phase_nxt = PH_DELTA;
          end
          if (chunk_nxt == 32'd0) begin
            if (complete) begin
              r.track_done = 1'b1;
              phase_nxt = PH_TTAG;
              cnt_nxt = 3'd0;
            end else begin
              cause = mfsp_pkg::ERR_OVERRUN;
            end
          end
        end
      end
    endcase
    if (cause == mfsp_pkg::ERR_NONE && final_byte &&
        !(phase_nxt == PH_TTAG && cnt_nxt == 3'd0))
      cause = mfsp_pkg::ERR_TRUNCATED;
    if (cause != mfsp_pkg::ERR_NONE) begin
      r = '0;
      r.kind = mfsp_pkg::KIND_ERROR;
      r.error_cause = cause;
      err_nxt = 1'b1;
      have = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HTAG; cnt_r <= '0; word_r <= '0;
      hw0_r <= '0; hw1_r <= '0; hw2_r <= '0;
      rs_r <= '0; rsv_r <= 1'b0; chunk_r <= '0; delta_r <= '0;
      pay_r <= '0; held_r <= '0; err_r <= 1'b0;
    end else if (take && !err_r) begin
      phase_r <= phase_nxt; cnt_r <= cnt_nxt; word_r <= word_nxt;
      hw0_r <= hw0_nxt; hw1_r <= hw1_nxt; hw2_r <= hw2_nxt;
      rs_r <= rs_nxt; rsv_r <= rsv_nxt; chunk_r <= chunk_nxt; delta_r <= delta_nxt;
      pay_r <= pay_nxt; held_r <= held_nxt; err_r <= err_nxt;
    end
  end

  assign res_valid = take && !err_r && have;
  assign res = r;

endmodule

// File: hw/rtl/mfsp_queue.sv
// ----------------------------------------------------------------------------
// MIDI file stream parser result queue
// Two-entry queue holding result records ahead of the output port.
// ----------------------------------------------------------------------------
module mfsp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mfsp_pkg::result_t push_data,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output mfsp_pkg::result_t out_data
);

  mfsp_pkg::result_t mem_r [2];
  logic              wp_r, rp_r;
  logic [1:0]        cnt_r;
  logic              pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign space     = (cnt_r != 2'd2) || out_ready;
  assign out_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: hw/rtl/midi_file_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// Each result record is registered in the result queue before it reaches the out_ ports.
// Throughput: one byte per cycle; the parser holds off only when both
// entries of the two-deep result queue are full and the output is stalled.
// Reset: synchronous active-low rst_n returns the parser to expect the
// header tag and empties the result queue; the first error latches until reset.
// ----------------------------------------------------------------------------
module midi_file_stream_parser_unit #(
  parameter int DELTA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [31:0] out_delta_time,
  output logic [3:0]  out_channel,
  output logic [7:0]  out_event_code,
  output logic [7:0]  out_data_first,
  output logic [7:0]  out_data_second,
  output logic [31:0] out_length,
  output logic [15:0] out_header_format,
  output logic [15:0] out_header_tracks,
  output logic [15:0] out_header_division,
  output logic        out_track_done,
  output logic [2:0]  out_error_cause
);

  logic              space, res_valid;
  mfsp_pkg::result_t res, q;

  assign in_ready = space;

  mfsp_front #(.DELTA_WIDTH(DELTA_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n), .take(in_valid && in_ready),
    .data_byte(in_data_byte), .final_byte(in_final_byte),
    .res_valid(res_valid), .res(res)
  );

  mfsp_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(res_valid), .push_data(res),
    .space(space), .out_valid(out_valid), .out_ready(out_ready), .out_data(q)
  );

  assign out_kind            = q.kind;
  assign out_delta_time      = q.delta_time;
  assign out_channel         = q.channel;
  assign out_event_code      = q.event_code;
  assign out_data_first      = q.data_first;
  assign out_data_second     = q.data_second;
  assign out_length          = q.length;
  assign out_header_format   = q.header_format;
  assign out_header_tracks   = q.header_tracks;
  assign out_header_division = q.header_division;
  assign out_track_done      = q.track_done;
  assign out_error_cause     = q.error_cause;

endmodule
